### rtl/core/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic enq;
      logic deq;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue.
`default_nettype none

// Bounded priority queue of DEPTH words kept sorted in a row of cells, largest
// priority at the front and equal priorities in arrival order. Each request word
// either enqueues a value with its priority or dequeues the head, and yields one
// response word with the removed value, a status code, the new head and the empty
// and full flags. Every cell compares its priority with the incoming one in the
// same cycle, so the whole insert or removal takes the accept cycle; the response
// is then held in the response state until taken, and the next request is
// accepted once the response has been taken.
// Dequeue on an empty queue returns status 1 and zero; enqueue to a full queue is
// dropped with status 2.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH          = 16,
   parameter int VALUE_WIDTH    = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_operation,
   input  wire logic [VALUE_WIDTH-1:0]    req_item_value,
   input  wire logic [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [VALUE_WIDTH-1:0]         rsp_removed_value,
   output logic [1:0]                     rsp_status,
   output logic [VALUE_WIDTH-1:0]         rsp_head_value,
   output logic                           rsp_is_empty,
   output logic                           rsp_is_full
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   spq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat)
   );

   spq_datapath #(
      .DEPTH          (DEPTH),
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_removed_value (rsp_removed_value),
      .rsp_head_value    (rsp_head_value),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

endmodule

`default_nettype wire

### rtl/core/spq_ctrl.sv
// Controller state machine for the stable priority queue.
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output dp_cmd_type       dp_cmd,
   input  wire dp_stat_type dp_stat
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_RESP);
      dp_cmd.load   = accept;
      dp_cmd.enq    = accept && (op_type'(req_operation) == OP_ENQUEUE) && !dp_stat.full;
      dp_cmd.deq    = accept && (op_type'(req_operation) == OP_DEQUEUE) && !dp_stat.empty;
   end

   always_comb begin
      status_in = status_ff;
      if (accept) begin
         if (op_type'(req_operation) == OP_ENQUEUE) begin
            status_in = dp_stat.full ? STATUS_FULL : STATUS_OK;
         end else begin
            status_in = dp_stat.empty ? STATUS_EMPTY : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign rsp_status = 2'(status_ff);

endmodule

`default_nettype wire

### rtl/core/spq_datapath.sv
// Sorted cell array, entry count and result registers of the stable priority queue.
`default_nettype none

module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH          = 16,
   parameter int VALUE_WIDTH    = 32,
   parameter int PRIORITY_WIDTH = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                dp_cmd,
   output dp_stat_type                    dp_stat,
   input  wire logic [VALUE_WIDTH-1:0]    req_item_value,
   input  wire logic [PRIORITY_WIDTH-1:0] req_item_priority,
   output logic [VALUE_WIDTH-1:0]         rsp_removed_value,
   output logic [VALUE_WIDTH-1:0]         rsp_head_value,
   output logic                           rsp_is_empty,
   output logic                           rsp_is_full
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [VALUE_WIDTH-1:0]    removed_ff, removed_in;
   logic [VALUE_WIDTH-1:0]    cell_val_ff [DEPTH];
   logic [VALUE_WIDTH-1:0]    cell_val_in [DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_pri_ff [DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_pri_in [DEPTH];
   logic [DEPTH-1:0]          take;

   assign dp_stat.empty = (count_ff == '0);
   assign dp_stat.full  = (count_ff == CNT_W'(DEPTH));

   // A cell takes part in an insert when it holds a lower priority than the new
   // word or is the first free cell; the first such cell receives the new word.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      assign take[k] = ((CNT_W'(k) < count_ff) && (cell_pri_ff[k] < req_item_priority))
                       || (CNT_W'(k) == count_ff);

      always_comb begin
         cell_val_in[k] = cell_val_ff[k];
         cell_pri_in[k] = cell_pri_ff[k];
         if (dp_cmd.enq && take[k]) begin
            cell_val_in[k] = req_item_value;
            cell_pri_in[k] = req_item_priority;
            if (k > 0) begin
               if (take[(k > 0) ? k - 1 : 0]) begin
                  cell_val_in[k] = cell_val_ff[(k > 0) ? k - 1 : 0];
                  cell_pri_in[k] = cell_pri_ff[(k > 0) ? k - 1 : 0];
               end
            end
         end else if (dp_cmd.deq && (k < DEPTH - 1)) begin
            cell_val_in[k] = cell_val_ff[(k < DEPTH - 1) ? k + 1 : k];
            cell_pri_in[k] = cell_pri_ff[(k < DEPTH - 1) ? k + 1 : k];
         end
      end

      always_ff @(posedge clock) begin
         cell_val_ff[k] <= cell_val_in[k];
         cell_pri_ff[k] <= cell_pri_in[k];
      end
   end

   always_comb begin
      count_in   = count_ff;
      removed_in = removed_ff;
      if (dp_cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (dp_cmd.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (dp_cmd.load) begin
         removed_in = dp_cmd.deq ? cell_val_ff[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      removed_ff <= removed_in;
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_head_value    = dp_stat.empty ? '0 : cell_val_ff[0];
   assign rsp_is_empty      = dp_stat.empty;
   assign rsp_is_full       = dp_stat.full;

endmodule

`default_nettype wire

### rtl/core/stable_priority_queue_checker.sv
// Port-level checker for the stable priority queue and its bind statement.
`default_nettype none

module stable_priority_queue_checker
   import spq_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [VALUE_WIDTH-1:0] rsp_removed_value,
   input wire logic [1:0]             rsp_status,
   input wire logic [VALUE_WIDTH-1:0] rsp_head_value,
   input wire logic                   rsp_is_empty,
   input wire logic                   rsp_is_full
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_value)
         && $stable(rsp_status))
      else $error("Response word changed while stalled.");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("Queue reported empty and full together.");

   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == 2'(STATUS_EMPTY)) |->
         rsp_is_empty && (rsp_removed_value == '0))
      else $error("Dequeue on empty queue reported wrongly.");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == 2'(STATUS_FULL)) |->
         rsp_is_full && (rsp_removed_value == '0))
      else $error("Dropped enqueue reported without a full queue.");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_head_value == '0))
      else $error("Empty queue reported a nonzero head.");

endmodule

bind stable_priority_queue stable_priority_queue_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (.*);

`default_nettype wire
